// File: design/double_ended_queue_assert.svh
// ----------------------------------------------------------------------------
// Double-ended queue assertion macros
// Shared concurrent assertion forms for the queue RTL.
// ----------------------------------------------------------------------------
`ifndef DOUBLE_ENDED_QUEUE_ASSERT_SVH
`define DOUBLE_ENDED_QUEUE_ASSERT_SVH

// Same-cycle implication, disabled in reset.
`define DEQ_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("deq assertion failed (same cycle)");

// Next-cycle implication, disabled in reset.
`define DEQ_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("deq assertion failed (next cycle)");

`endif

// File: design/deq_pkg.sv
// ----------------------------------------------------------------------------
// Double-ended queue package
// Payload types, codes and sizes shared by the queue RTL.
// ----------------------------------------------------------------------------
package deq_pkg;

   localparam int CAPACITY   = 256;
   localparam int DATA_WIDTH = 32;
   localparam int PTR_W      = $clog2(CAPACITY);
   localparam int CNT_W      = $clog2(CAPACITY + 1);
   localparam int POS_W      = 8;

   typedef logic signed [DATA_WIDTH-1:0] data_type;
   typedef logic [PTR_W-1:0]             ptr_type;
   typedef logic [CNT_W-1:0]             cnt_type;

   typedef enum logic [2:0] {
      ACT_PUSH_BACK  = 3'd0,
      ACT_PUSH_FRONT = 3'd1,
      ACT_POP_BACK   = 3'd2,
      ACT_POP_FRONT  = 3'd3,
      ACT_READ       = 3'd4,
      ACT_CLEAR      = 3'd5
   } action_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_FULL  = 2'd1,
      ST_EMPTY = 2'd2,
      ST_RANGE = 2'd3
   } status_type;

   typedef struct packed {
      action_type       action;
      data_type         value;
      logic [POS_W-1:0] position;
   } req_type;

   typedef struct packed {
      status_type status;
      data_type   data_out;
      data_type   front_value;
      data_type   back_value;
      cnt_type    item_count;
      logic       is_empty;
   } rsp_type;

endpackage

// File: design/double_ended_queue.sv
// ----------------------------------------------------------------------------
// Double-ended queue
// Bounded ring store with push/pop at both ends, indexed read and clear.
// ----------------------------------------------------------------------------
//
//   channel   ports                         handshake
//   --------  ----------------------------  ----------------------------------
//   request   start, busy, req_payload      taken when start && !busy
//   response  rsp_valid, rsp_payload        one-cycle strobe, no back-pressure
//
// One item per cycle while busy is low; its result is strobed in the cycle after acceptance.
// The latency is set by the registered read port of the slot memory.
// Front and back values live in registers; a pop refetches the new end through
// the single read port and forwards it until the next item is taken.
// busy is high only for the first cycle after reset; no clearing pass.
// The receiver cannot stall, so acceptance never waits on the response side.
// ----------------------------------------------------------------------------
`include "double_ended_queue_assert.svh"

module double_ended_queue
   import deq_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_payload,
   output logic    rsp_valid,
   output rsp_type rsp_payload
);

   data_type   slots_mem [CAPACITY];

   ptr_type    head_ff, head_in;
   cnt_type    count_ff, count_in;
   data_type   front_ff, front_in;
   data_type   back_ff, back_in;
   data_type   rd_data_ff;
   data_type   pop_data_ff, pop_data_in;
   status_type status_ff, status_in;
   logic       front_fwd_ff, front_fwd_in;
   logic       back_fwd_ff, back_fwd_in;
   logic       rd_sel_ff, rd_sel_in;
   logic       rsp_valid_ff;
   logic       busy_ff;

   logic       accept;
   logic       full;
   logic       empty;
   logic       wr_en;
   ptr_type    wr_addr;
   ptr_type    rd_addr;
   ptr_type    count_lo;
   data_type   front_cur;
   data_type   back_cur;

   assign accept    = start && !busy_ff;
   assign full      = (count_ff == CNT_W'(CAPACITY));
   assign empty     = (count_ff == '0);
   assign count_lo  = count_ff[PTR_W-1:0];
   assign front_cur = front_fwd_ff ? rd_data_ff : front_ff;
   assign back_cur  = back_fwd_ff  ? rd_data_ff : back_ff;

   always_comb begin
      head_in      = head_ff;
      count_in     = count_ff;
      front_in     = front_cur;
      back_in      = back_cur;
      front_fwd_in = 1'b0;
      back_fwd_in  = 1'b0;
      rd_sel_in    = 1'b0;
      pop_data_in  = '0;
      status_in    = ST_OK;
      wr_en        = 1'b0;
      wr_addr      = head_ff + count_lo;
      rd_addr      = head_ff + PTR_W'(req_payload.position);
      unique case (req_payload.action)
         ACT_PUSH_BACK: begin
            if (full) begin
               status_in = ST_FULL;
            end else begin
               wr_en    = 1'b1;
               wr_addr  = head_ff + count_lo;
               count_in = count_ff + CNT_W'(1);
               back_in  = req_payload.value;
               if (empty) begin
                  front_in = req_payload.value;
               end
            end
         end
         ACT_PUSH_FRONT: begin
            if (full) begin
               status_in = ST_FULL;
            end else begin
               wr_en    = 1'b1;
               wr_addr  = head_ff - PTR_W'(1);
               head_in  = head_ff - PTR_W'(1);
               count_in = count_ff + CNT_W'(1);
               front_in = req_payload.value;
               if (empty) begin
                  back_in = req_payload.value;
               end
            end
         end
         ACT_POP_BACK: begin
            if (empty) begin
               status_in = ST_EMPTY;
            end else begin
               pop_data_in = back_cur;
               count_in    = count_ff - CNT_W'(1);
               rd_addr     = head_ff + count_lo - PTR_W'(2);
               if (count_ff == CNT_W'(2)) begin
                  back_in = front_cur;
               end else if (count_ff > CNT_W'(2)) begin
                  back_fwd_in = 1'b1;
               end
            end
         end
         ACT_POP_FRONT: begin
            if (empty) begin
               status_in = ST_EMPTY;
            end else begin
               pop_data_in = front_cur;
               count_in    = count_ff - CNT_W'(1);
               head_in     = head_ff + PTR_W'(1);
               rd_addr     = head_ff + PTR_W'(1);
               if (count_ff == CNT_W'(2)) begin
                  front_in = back_cur;
               end else if (count_ff > CNT_W'(2)) begin
                  front_fwd_in = 1'b1;
               end
            end
         end
         ACT_READ: begin
            if (CNT_W'(req_payload.position) >= count_ff) begin
               status_in = ST_RANGE;
            end else begin
               rd_sel_in = 1'b1;
            end
         end
         ACT_CLEAR: begin
            head_in  = '0;
            count_in = '0;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff      <= '0;
         count_ff     <= '0;
         front_fwd_ff <= 1'b0;
         back_fwd_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         busy_ff      <= 1'b1;
      end else begin
         busy_ff      <= 1'b0;
         rsp_valid_ff <= accept;
         if (accept) begin
            head_ff      <= head_in;
            count_ff     <= count_in;
            front_fwd_ff <= front_fwd_in;
            back_fwd_ff  <= back_fwd_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         front_ff    <= front_in;
         back_ff     <= back_in;
         pop_data_ff <= pop_data_in;
         status_ff   <= status_in;
         rd_sel_ff   <= rd_sel_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rd_data_ff <= slots_mem[rd_addr];
         if (wr_en) begin
            slots_mem[wr_addr] <= req_payload.value;
         end
      end
   end

   assign busy      = busy_ff;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      rsp_payload.status      = status_ff;
      rsp_payload.data_out    = rd_sel_ff ? rd_data_ff : pop_data_ff;
      rsp_payload.front_value = empty ? '0 : front_cur;
      rsp_payload.back_value  = empty ? '0 : back_cur;
      rsp_payload.item_count  = count_ff;
      rsp_payload.is_empty    = empty;
   end

   `DEQ_ASSERT_NOW(a_count_bound, clock, reset, 1'b1, count_ff <= CNT_W'(CAPACITY))
   `DEQ_ASSERT_NOW(a_fwd_exclusive, clock, reset, front_fwd_ff, !back_fwd_ff)
   `DEQ_ASSERT_NEXT(a_rsp_follows, clock, reset, accept, rsp_valid)
   `DEQ_ASSERT_NOW(a_empty_refusal, clock, reset, rsp_valid && (status_ff == ST_EMPTY), empty)
   `DEQ_ASSERT_NOW(a_full_refusal, clock, reset, rsp_valid && (status_ff == ST_FULL), full)

endmodule

// File: bench/tb_double_ended_queue.sv
// ----------------------------------------------------------------------------
// Double-ended queue testbench
// Drives push, pop, indexed read, clear and spare action items through the
// command port, keeps a mirror of the ring store to predict each response,
// and checks every strobed response field by field in arrival order.
// ----------------------------------------------------------------------------
module tb_double_ended_queue
   import deq_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int STALL_LIMIT = 2000;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    start = 1'b0;
   logic    busy;
   req_type req_payload = '0;
   logic    rsp_valid;
   rsp_type rsp_payload;

   data_type mirror_slots [CAPACITY];
   ptr_type  mirror_head  = '0;
   cnt_type  mirror_count = '0;

   rsp_type expected_outcomes [$];

   int items_sent      = 0;
   int results_checked = 0;
   int refusals        = 0;
   int errors          = 0;
   int idle_cycles     = 0;

   double_ended_queue dut (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_payload (rsp_payload)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic req_type make_req(input action_type act, input data_type val,
                                        input logic [POS_W-1:0] pos);
      req_type r;
      r.action   = act;
      r.value    = val;
      r.position = pos;
      return r;
   endfunction

   // Ring store mirror: advances the queue by one item and returns its response.
   function automatic rsp_type deque_step(input req_type r);
      rsp_type o;
      o = '0;
      o.status = ST_OK;
      case (r.action)
         ACT_PUSH_BACK: begin
            if (mirror_count >= CAPACITY) begin
               o.status = ST_FULL;
            end else begin
               mirror_slots[ptr_type'(mirror_head + mirror_count)] = r.value;
               mirror_count++;
            end
         end
         ACT_PUSH_FRONT: begin
            if (mirror_count >= CAPACITY) begin
               o.status = ST_FULL;
            end else begin
               mirror_head = mirror_head - 1'b1;
               mirror_slots[mirror_head] = r.value;
               mirror_count++;
            end
         end
         ACT_POP_BACK: begin
            if (mirror_count == 0) begin
               o.status = ST_EMPTY;
            end else begin
               o.data_out = mirror_slots[ptr_type'(mirror_head + mirror_count - 1)];
               mirror_count--;
            end
         end
         ACT_POP_FRONT: begin
            if (mirror_count == 0) begin
               o.status = ST_EMPTY;
            end else begin
               o.data_out = mirror_slots[mirror_head];
               mirror_head = mirror_head + 1'b1;
               mirror_count--;
            end
         end
         ACT_READ: begin
            if (r.position >= mirror_count) begin
               o.status = ST_RANGE;
            end else begin
               o.data_out = mirror_slots[ptr_type'(mirror_head + r.position)];
            end
         end
         ACT_CLEAR: begin
            mirror_head  = '0;
            mirror_count = '0;
         end
         default: ;
      endcase
      if (mirror_count != 0) begin
         o.front_value = mirror_slots[mirror_head];
         o.back_value  = mirror_slots[ptr_type'(mirror_head + mirror_count - 1)];
      end
      o.item_count = mirror_count;
      o.is_empty   = (mirror_count == 0);
      if (o.status != ST_OK) refusals++;
      return o;
   endfunction

   // Called at a falling edge; returns at the falling edge after acceptance.
   task automatic send_item(input req_type item);
      start       <= 1'b1;
      req_payload <= item;
      do @(posedge clock); while (busy);
      expected_outcomes.insert(expected_outcomes.size(), deque_step(item));
      items_sent++;
      @(negedge clock);
   endtask

   task automatic random_gap();
      int roll;
      int n;
      roll = $urandom_range(0, 99);
      if (roll < 55) n = 0;
      else if (roll < 90) n = $urandom_range(1, 3);
      else n = $urandom_range(6, 30);
      if (n > 0) begin
         start <= 1'b0;
         repeat (n) @(negedge clock);
      end
   endtask

   task automatic wait_for_outstanding();
      start <= 1'b0;
      do @(negedge clock); while (expected_outcomes.size() != 0);
   endtask

   task automatic test_directed();
      send_item(make_req(ACT_POP_BACK, 32'sd7, 8'd0));
      send_item(make_req(ACT_POP_FRONT, -32'sd7, 8'd0));
      send_item(make_req(ACT_READ, '0, 8'd0));
      send_item(make_req(ACT_READ, '0, 8'd255));
      random_gap();
      send_item(make_req(ACT_PUSH_BACK, 32'sh7fff_ffff, 8'd0));
      send_item(make_req(ACT_PUSH_FRONT, 32'sh8000_0000, 8'd255));
      send_item(make_req(ACT_PUSH_BACK, 32'sd0, 8'd0));
      send_item(make_req(ACT_PUSH_FRONT, -32'sd1, 8'd0));
      send_item(make_req(ACT_PUSH_BACK, 32'sh5555_5555, 8'd0));
      send_item(make_req(ACT_PUSH_FRONT, 32'shaaaa_aaaa, 8'd0));
      random_gap();
      send_item(make_req(ACT_READ, 32'sd99, 8'd0));
      send_item(make_req(ACT_READ, '0, 8'd5));
      send_item(make_req(ACT_READ, '0, 8'd6));
      send_item(make_req(ACT_READ, '1, 8'd255));
      send_item(make_req(action_type'(3'd6), 32'sh1234_5678, 8'd1));
      send_item(make_req(action_type'(3'd7), '1, 8'd255));
      send_item(make_req(ACT_POP_BACK, '0, 8'd0));
      send_item(make_req(ACT_POP_FRONT, '0, 8'd0));
      random_gap();
      send_item(make_req(ACT_CLEAR, 32'sd5, 8'd3));
      send_item(make_req(ACT_POP_BACK, '0, 8'd0));
      send_item(make_req(ACT_PUSH_FRONT, 32'sd123, 8'd0));
      send_item(make_req(ACT_PUSH_BACK, 32'sd456, 8'd0));
      send_item(make_req(ACT_READ, '0, 8'd1));
      send_item(make_req(ACT_POP_BACK, '0, 8'd0));
      send_item(make_req(ACT_POP_FRONT, '0, 8'd0));
   endtask

   // Back to back, no gaps: fill both ends to capacity, hit full, then drain.
   task automatic test_fill_and_drain();
      send_item(make_req(ACT_CLEAR, '0, '0));
      for (int i = 0; i < CAPACITY; i++) begin
         send_item(make_req(i[0] ? ACT_PUSH_FRONT : ACT_PUSH_BACK, $urandom,
                            POS_W'($urandom)));
      end
      send_item(make_req(ACT_PUSH_BACK, $urandom, '0));
      send_item(make_req(ACT_PUSH_FRONT, $urandom, '0));
      send_item(make_req(ACT_READ, '0, 8'd255));
      send_item(make_req(ACT_READ, '0, 8'd0));
      send_item(make_req(ACT_READ, '0, POS_W'($urandom)));
      for (int i = 0; i < CAPACITY; i++) begin
         send_item(make_req(i[1] ? ACT_POP_FRONT : ACT_POP_BACK, $urandom,
                            POS_W'($urandom)));
      end
      send_item(make_req(ACT_POP_FRONT, '0, '0));
      send_item(make_req(ACT_POP_BACK, '0, '0));
   endtask

   task automatic test_random_mix();
      int               pick;
      action_type       act;
      data_type         val;
      logic [POS_W-1:0] pos;
      for (int i = 0; i < 230; i++) begin
         pick = $urandom_range(0, 99);
         val  = $urandom;
         pos  = POS_W'($urandom);
         if (pick < 20) act = ACT_PUSH_BACK;
         else if (pick < 38) act = ACT_PUSH_FRONT;
         else if (pick < 54) act = ACT_POP_BACK;
         else if (pick < 70) act = ACT_POP_FRONT;
         else if (pick < 93) begin
            act = ACT_READ;
            if (mirror_count != 0 && pick < 88) begin
               pos = POS_W'($urandom_range(0, mirror_count - 1));
            end
         end
         else if (pick < 95) act = ACT_CLEAR;
         else act = action_type'(3'($urandom_range(6, 7)));
         send_item(make_req(act, val, pos));
         if (i % 75 == 74) wait_for_outstanding();
         else random_gap();
      end
   endtask

   task automatic report_field(input string field, input logic [31:0] want,
                               input logic [31:0] got);
      if (want !== got) begin
         errors++;
         $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
      end
   endtask

   always @(posedge clock) begin : check_results
      rsp_type want;
      if (!reset && rsp_valid) begin
         if (expected_outcomes.size() == 0) begin
            errors++;
            $display("%0t: unexpected response, expected none, actual %h", $time,
                     rsp_payload);
         end else begin
            want = expected_outcomes[0];
            expected_outcomes.delete(0);
            results_checked++;
            report_field("status", 32'(want.status), 32'(rsp_payload.status));
            report_field("data_out", want.data_out, rsp_payload.data_out);
            report_field("front_value", want.front_value, rsp_payload.front_value);
            report_field("back_value", want.back_value, rsp_payload.back_value);
            report_field("item_count", 32'(want.item_count),
                         32'(rsp_payload.item_count));
            report_field("is_empty", 32'(want.is_empty), 32'(rsp_payload.is_empty));
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      repeat (5) @(negedge clock);
      reset <= 1'b0;
      test_directed();
      test_fill_and_drain();
      test_random_mix();
      wait_for_outstanding();
      repeat (4) @(negedge clock);
      if (expected_outcomes.size() != 0) begin
         errors++;
         $display("%0t: %0d responses never arrived", $time, expected_outcomes.size());
      end
      $display("Sent %0d items, checked %0d responses, %0d of them refusals;",
               items_sent, results_checked, refusals);
      $display("pushes and pops at both ends, indexed reads, clears, spare codes, empty to full.");
      if (errors == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
